/* src/bcm_pkg.sv */
// Shared types, constants and helpers for the byte-code machine.
// No dependencies; every file except bcm_ram imports this package.
package bcm_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int REG_COUNT = 16;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int REG_AW    = (REG_COUNT > 2) ? $clog2(REG_COUNT) : 1;
  localparam int CLR_N     = (MEM_BYTES > REG_COUNT) ? MEM_BYTES : REG_COUNT;
  localparam int CLR_W     = $clog2(CLR_N);
  localparam int Q_DEPTH   = 2;

  localparam logic [2:0] HC_RUN    = 3'd0;
  localparam logic [2:0] HC_BOUNDS = 3'd1;
  localparam logic [2:0] HC_OPCODE = 3'd2;
  localparam logic [2:0] HC_COND   = 3'd3;
  localparam logic [2:0] HC_HALT   = 3'd4;

  localparam logic [1:0] FL_NONE = 2'd0;
  localparam logic [1:0] FL_LT   = 2'd1;
  localparam logic [1:0] FL_GT   = 2'd2;
  localparam logic [1:0] FL_EQ   = 2'd3;

  localparam logic [7:0] OP_LOAD  = 8'd0;
  localparam logic [7:0] OP_STORE = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_SHL   = 8'd4;
  localparam logic [7:0] OP_SHR   = 8'd5;
  localparam logic [7:0] OP_JMP   = 8'd6;
  localparam logic [7:0] OP_CMP   = 8'd7;
  localparam logic [7:0] OP_HALT  = 8'd8;

  localparam logic [7:0] CC_ALWAYS = 8'd0;
  localparam logic [7:0] CC_LT     = 8'd1;
  localparam logic [7:0] CC_GT     = 8'd2;
  localparam logic [7:0] CC_LE     = 8'd3;
  localparam logic [7:0] CC_GE     = 8'd4;
  localparam logic [7:0] CC_EQ     = 8'd5;

  // classified input word, front to back
  typedef struct packed {
    logic              is_step;
    logic              wr_ok;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [2:0]  halt_code;
    logic [31:0] pc;
    logic [1:0]  flag;
    logic        rwv;
    logic [3:0]  rn;
    logic [31:0] rval;
    logic        mwv;
    logic [31:0] ma;
    logic [31:0] mval;
  } result_t;

  function automatic logic reg_ok(logic [7:0] b);
    return !b[7] && (32'(b[6:0]) < REG_COUNT);
  endfunction

  // pc + k still inside memory
  function automatic logic fits(logic [31:0] pc, logic [2:0] k);
    return ({1'b0, pc} + {30'b0, k}) < 33'(MEM_BYTES);
  endfunction

endpackage

/* src/bcm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bcm_front.sv */
// Front end: accepts input words, classifies them and queues them.
// Uses bcm_pkg.
module bcm_front
  import bcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [15:0]          address,
  input  logic signed [7:0]    byte_value,
  input  logic                 pop,
  output q_head_t              head
);

  item_t      q [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      cls;

  assign in_stall = (count == 2'(Q_DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    cls.is_step = op;
    cls.wr_ok   = {1'b0, address} < 17'(MEM_BYTES);
    cls.waddr   = address[MEM_AW-1:0];
    cls.wdata   = byte_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

endmodule

/* src/bcm_exec.sv */
// Back end: sequencer that runs writes and instruction steps against the
// byte memory and register file, plus the result register. Uses bcm_pkg, bcm_ram.
module bcm_exec
  import bcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_head_t head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_CLEAR  = 8'b00000010,
    S_FETCH  = 8'b00000100,
    S_DECODE = 8'b00001000,
    S_REG    = 8'b00010000,
    S_EXEC   = 8'b00100000,
    S_MEM    = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t      state;
  logic [2:0]  cnt;
  logic [CLR_W-1:0] clr;
  logic [31:0] pc;
  logic [1:0]  flag;
  logic [2:0]  halt;
  logic [55:0] ibs;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] ea;
  logic [31:0] ldw;
  logic        rwv;
  logic [3:0]  rn;
  logic [31:0] rval;
  logic        mwv;

  // memory ports
  logic              m_we;
  logic [MEM_AW-1:0] m_waddr;
  logic [7:0]        m_wdata;
  logic [MEM_AW-1:0] m_raddr;
  logic [7:0]        m_rdata;
  logic              r_we;
  logic [REG_AW-1:0] r_waddr;
  logic [31:0]       r_wdata;
  logic [REG_AW-1:0] r_raddr;
  logic [31:0]       r_rdata;

  bcm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  bcm_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // instruction bytes
  logic [7:0]  ib0, ib1, ib2, ib3, ib5;
  logic [31:0] jmp_tgt;
  logic [31:0] dir_addr;
  logic        mode_ind;
  logic        is_load;
  assign ib0      = ibs[7:0];
  assign ib1      = ibs[15:8];
  assign ib2      = ibs[23:16];
  assign ib3      = ibs[31:24];
  assign ib5      = ibs[47:40];
  assign jmp_tgt  = ibs[39:8];
  assign dir_addr = ibs[55:24];
  assign mode_ind = (ib2 != 8'd0);
  assign is_load  = (ib0 == OP_LOAD);

  // decode checks
  logic       d_bounds;
  logic       d_cond;
  logic       d_take;
  logic [7:0] rx;
  logic [7:0] ry;
  always_comb begin
    d_bounds = 1'b0;
    d_cond   = 1'b0;
    rx       = ib1;
    ry       = ib2;
    unique case (ib0)
      OP_LOAD, OP_STORE: begin
        rx = ib3;
        ry = ib1;
        d_bounds = !fits(pc, 3'd6) || !reg_ok(ib1) ||
                   (mode_ind ? (!reg_ok(ib3) || 32'(ib3[6:0]) >= MEM_BYTES)
                             : !fits(pc, 3'd7));
      end
      OP_ADD, OP_SUB: begin
        rx = ib2;
        ry = ib3;
        d_bounds = !fits(pc, 3'd3) || !reg_ok(ib1) || !reg_ok(ib2) || !reg_ok(ib3);
      end
      OP_SHL, OP_SHR: begin
        d_bounds = !fits(pc, 3'd3) || !reg_ok(ib1) || !reg_ok(ib3);
      end
      OP_JMP: begin
        d_bounds = !fits(pc, 3'd5);
        d_cond   = ib5 > CC_EQ;
      end
      OP_CMP: begin
        d_bounds = !fits(pc, 3'd2) || !reg_ok(ib1) || !reg_ok(ib2);
      end
      default: begin
      end
    endcase
    unique case (ib5)
      CC_ALWAYS: d_take = 1'b1;
      CC_LT:     d_take = (flag == FL_LT);
      CC_GT:     d_take = (flag == FL_GT);
      CC_LE:     d_take = (flag == FL_LT) || (flag == FL_EQ);
      CC_GE:     d_take = (flag == FL_GT) || (flag == FL_EQ);
      default:   d_take = (flag == FL_EQ);
    endcase
  end

  logic [31:0] ea_c;
  logic        ea_ok;
  logic [31:0] alu;
  assign ea_c  = mode_ind ? x : dir_addr;
  assign ea_ok = ({1'b0, ea_c} + 33'd4) < 33'(MEM_BYTES);

  always_comb begin
    unique case (ib0)
      OP_ADD:  alu = x + y;
      OP_SUB:  alu = x - y;
      OP_SHL:  alu = x << ib2[4:0];
      default: alu = 32'($signed(x) >>> ib2[4:0]);
    endcase
  end

  assign pop = (state == S_IDLE) && head.valid;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // RAM port steering
  always_comb begin
    m_we    = 1'b0;
    m_waddr = head.item.waddr;
    m_wdata = head.item.wdata;
    m_raddr = pc[MEM_AW-1:0] + MEM_AW'(cnt);
    r_we    = 1'b0;
    r_waddr = ib1[REG_AW-1:0];
    r_wdata = ldw;
    r_raddr = rx[REG_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        m_we    = 32'(clr) < MEM_BYTES;
        m_waddr = MEM_AW'(clr);
        m_wdata = 8'd0;
        r_we    = 32'(clr) < REG_COUNT;
        r_waddr = REG_AW'(clr);
        r_wdata = 32'd0;
      end
      S_IDLE: begin
        m_we = pop && !head.item.is_step && head.item.wr_ok;
      end
      S_REG: begin
        if (cnt != 3'd0) begin
          r_raddr = ry[REG_AW-1:0];
        end
      end
      S_EXEC: begin
        r_we    = (ib0 == OP_ADD) || (ib0 == OP_SUB) || (ib0 == OP_SHL) ||
                  (ib0 == OP_SHR);
        r_waddr = ((ib0 == OP_ADD) || (ib0 == OP_SUB)) ? ib1[REG_AW-1:0]
                                                       : ib3[REG_AW-1:0];
        r_wdata = alu;
      end
      S_MEM: begin
        m_raddr = ea[MEM_AW-1:0] + MEM_AW'(cnt);
        m_waddr = ea[MEM_AW-1:0] + MEM_AW'(cnt);
        m_wdata = y[{cnt[1:0], 3'b000} +: 8];
        m_we    = !is_load && (cnt < 3'd4);
        r_we    = is_load && (cnt == 3'd4);
        // last byte is still on the read port
        r_wdata = {m_rdata, ldw[31:8]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cnt       <= 3'd0;
      pc        <= 32'd0;
      flag      <= FL_NONE;
      halt      <= HC_RUN;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == CLR_N - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            rwv  <= 1'b0;
            rn   <= 4'd0;
            rval <= 32'd0;
            mwv  <= 1'b0;
            ea   <= 32'd0;
            y    <= 32'd0;
            cnt  <= 3'd0;
            state <= S_DONE;
            if (!head.item.is_step) begin
              if (!head.item.wr_ok) begin
                halt <= HC_BOUNDS;
              end
            end else if (halt == HC_RUN) begin
              if ({1'b0, pc} >= 33'(MEM_BYTES)) begin
                halt <= HC_BOUNDS;
              end else begin
                state <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            ibs <= {m_rdata, ibs[55:8]};
          end
          if (cnt == 3'd7) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          cnt   <= 3'd0;
          state <= S_DONE;
          priority if (d_bounds) begin
            halt <= HC_BOUNDS;
          end else if (d_cond) begin
            halt <= HC_COND;
          end else if (ib0 == OP_JMP) begin
            pc <= d_take ? jmp_tgt : pc + 32'd6;
          end else if (ib0 == OP_HALT) begin
            halt <= HC_HALT;
          end else if (ib0 > OP_HALT) begin
            halt <= HC_OPCODE;
          end else begin
            state <= S_REG;
          end
        end
        S_REG: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            x <= r_rdata;
          end
          if (cnt == 3'd2) begin
            y     <= r_rdata;
            cnt   <= 3'd0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          unique case (ib0)
            OP_LOAD, OP_STORE: begin
              if (!ea_ok) begin
                halt <= HC_BOUNDS;
                y    <= 32'd0;
              end else begin
                ea    <= ea_c;
                pc    <= pc + 32'd7;
                state <= S_MEM;
              end
            end
            OP_CMP: begin
              flag <= (x < y) ? FL_LT : (x > y) ? FL_GT : FL_EQ;
              pc   <= pc + 32'd3;
            end
            default: begin
              rwv  <= 1'b1;
              rn   <= r_we ? ((ib0 == OP_ADD) || (ib0 == OP_SUB) ? ib1[3:0] : ib3[3:0])
                           : 4'd0;
              rval <= alu;
              pc   <= pc + 32'd4;
            end
          endcase
        end
        S_MEM: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            ldw <= {m_rdata, ldw[31:8]};
          end
          if (!is_load && cnt == 3'd3) begin
            mwv   <= 1'b1;
            state <= S_DONE;
          end
          if (is_load && cnt == 3'd4) begin
            rwv   <= 1'b1;
            rn    <= ib1[3:0];
            rval  <= {m_rdata, ldw[31:8]};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      res.halt_code <= halt;
      res.pc        <= pc;
      res.flag      <= flag;
      res.rwv       <= rwv;
      res.rn        <= rn;
      res.rval      <= rval;
      res.mwv       <= mwv;
      res.ma        <= mwv ? ea : 32'd0;
      res.mval      <= mwv ? y : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_busy_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_REG || state == S_EXEC || state == S_MEM)
      |-> halt == HC_RUN)
    else $error("execution state entered while halted");

  a_pc_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != S_DECODE && state != S_EXEC) |=> $stable(pc))
    else $error("pc changed outside decode/execute");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised without completion");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE && head.valid))
    else $error("queue popped while busy");
`endif

endmodule

/* src/byte_code_machine_step.sv */
// Channel  | handshake            | payload
// in       | in_valid / in_stall  | op, address, byte_value
// out      | out_valid / out_stall| halt_code .. mem_value
// Step timing is set by the single byte-read port of the memory (7 fetch reads
// plus 4 data reads for a load).
// After reset a clearing pass over max(MEM_BYTES, REG_COUNT) addresses (4096) runs;
// input words are queued (two deep) meanwhile. Output stall holds the result
// register; the sequencer waits in its final state until it is free.
// Top level: front queue plus execution back end. Uses bcm_pkg, bcm_front, bcm_exec.
module byte_code_machine_step
  import bcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [15:0]        address,
  input  logic signed [7:0]  byte_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         halt_code,
  output logic [31:0]        program_counter,
  output logic [1:0]         compare_flag,
  output logic               reg_write_valid,
  output logic [3:0]         reg_number,
  output logic signed [31:0] reg_value,
  output logic               mem_write_valid,
  output logic [31:0]        mem_address,
  output logic signed [31:0] mem_value
);

  q_head_t head;
  logic    pop;
  result_t res;

  bcm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .address(address), .byte_value(byte_value),
    .pop(pop), .head(head)
  );

  bcm_exec u_exec (
    .clk(clk), .rst(rst), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign halt_code       = res.halt_code;
  assign program_counter = res.pc;
  assign compare_flag    = res.flag;
  assign reg_write_valid = res.rwv;
  assign reg_number      = res.rn;
  assign reg_value       = res.rval;
  assign mem_write_valid = res.mwv;
  assign mem_address     = res.ma;
  assign mem_value       = res.mval;

endmodule

/* bench/byte_code_machine_step_test.sv */
// Self-checking bench for byte_code_machine_step: directed table, then random programs.
// Predicts every result word in-bench and compares it field by field.
// Depends on bcm_pkg and the block under test.
module byte_code_machine_step_test;
  import bcm_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic               op = 0;
  logic [15:0]        address = 0;
  logic signed [7:0]  byte_value = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [2:0]         halt_code;
  logic [31:0]        program_counter;
  logic [1:0]         compare_flag;
  logic               reg_write_valid;
  logic [3:0]         reg_number;
  logic signed [31:0] reg_value;
  logic               mem_write_valid;
  logic [31:0]        mem_address;
  logic signed [31:0] mem_value;

  byte_code_machine_step dut (.*);

  always #5 clk = ~clk;

  // machine image kept by the bench
  logic [7:0]  mem_img [MEM_BYTES];
  logic [31:0] regs_img [REG_COUNT];
  logic [31:0] pc_img;
  logic [1:0]  flag_img;
  logic [2:0]  halt_img;

  result_t expected_q [$];
  result_t got_exp;
  int      errors = 0;
  int      n_items = 0;
  bit      quiet_in = 0;
  int      stall_left = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  function automatic int sb(longint a);
    logic signed [7:0] b;
    b = mem_img[a % MEM_BYTES];
    return b;
  endfunction

  function automatic logic [31:0] word_at(longint a);
    return {mem_img[(a + 3) % MEM_BYTES], mem_img[(a + 2) % MEM_BYTES],
            mem_img[(a + 1) % MEM_BYTES], mem_img[a % MEM_BYTES]};
  endfunction

  function automatic bit reg_good(int r);
    return r >= 0 && r < REG_COUNT;
  endfunction

  task automatic exec_instr(ref result_t r);
    longint pc, addr, ea;
    int opc, a, b, c, mode;
    logic [31:0] res, s, target;
    logic [4:0] sh;
    bit take;
    pc = pc_img;
    if (pc >= MEM_BYTES) begin halt_img = HC_BOUNDS; return; end
    opc = sb(pc);
    if (opc == OP_LOAD || opc == OP_STORE) begin
      if (pc + 6 >= MEM_BYTES) begin halt_img = HC_BOUNDS; return; end
      a = sb(pc + 1);
      mode = sb(pc + 2);
      if (mode == 0) begin
        if (!(pc + 7 < MEM_BYTES)) begin halt_img = HC_BOUNDS; return; end
        addr = word_at(pc + 3);
      end else begin
        b = sb(pc + 3);
        if (b < 0) begin halt_img = HC_BOUNDS; return; end
        addr = b;
      end
      if (!reg_good(a) || addr >= MEM_BYTES) begin halt_img = HC_BOUNDS; return; end
      if (mode == 0) ea = addr;
      else begin
        if (addr >= REG_COUNT) begin halt_img = HC_BOUNDS; return; end
        ea = regs_img[addr];
      end
      if (!(ea + 4 < MEM_BYTES)) begin halt_img = HC_BOUNDS; return; end
      if (opc == OP_LOAD) begin
        regs_img[a] = word_at(ea);
        r.rwv = 1; r.rn = a[3:0]; r.rval = regs_img[a];
      end else begin
        for (int i = 0; i < 4; i++) mem_img[ea + i] = regs_img[a][8*i +: 8];
        r.mwv = 1; r.ma = ea[31:0]; r.mval = regs_img[a];
      end
      pc_img += 7;
    end else if (opc >= OP_ADD && opc <= OP_SHR) begin
      if (pc + 3 >= MEM_BYTES) begin halt_img = HC_BOUNDS; return; end
      a = sb(pc + 1);
      b = sb(pc + 2);
      c = sb(pc + 3);
      if (opc <= OP_SUB) begin
        if (!reg_good(a) || !reg_good(b) || !reg_good(c)) begin
          halt_img = HC_BOUNDS; return;
        end
        res = (opc == OP_ADD) ? regs_img[b] + regs_img[c] : regs_img[b] - regs_img[c];
        regs_img[a] = res;
        r.rwv = 1; r.rn = a[3:0]; r.rval = res;
      end else begin
        if (!reg_good(a) || !reg_good(c)) begin halt_img = HC_BOUNDS; return; end
        sh = b[4:0];
        s = regs_img[a];
        // kept apart so the right shift stays signed
        if (opc == OP_SHL) res = s << sh;
        else res = $signed(s) >>> sh;
        regs_img[c] = res;
        r.rwv = 1; r.rn = c[3:0]; r.rval = res;
      end
      pc_img += 4;
    end else if (opc == OP_JMP) begin
      if (pc + 5 >= MEM_BYTES) begin halt_img = HC_BOUNDS; return; end
      target = word_at(pc + 1);
      case (sb(pc + 5))
        CC_ALWAYS: take = 1;
        CC_LT:     take = flag_img == FL_LT;
        CC_GT:     take = flag_img == FL_GT;
        CC_LE:     take = flag_img == FL_LT || flag_img == FL_EQ;
        CC_GE:     take = flag_img == FL_GT || flag_img == FL_EQ;
        CC_EQ:     take = flag_img == FL_EQ;
        default: begin halt_img = HC_COND; return; end
      endcase
      pc_img = take ? target : pc_img + 6;
    end else if (opc == OP_CMP) begin
      if (pc + 2 >= MEM_BYTES) begin halt_img = HC_BOUNDS; return; end
      a = sb(pc + 1);
      b = sb(pc + 2);
      if (!reg_good(a) || !reg_good(b)) begin halt_img = HC_BOUNDS; return; end
      flag_img = (regs_img[a] < regs_img[b]) ? FL_LT :
                 (regs_img[a] > regs_img[b]) ? FL_GT : FL_EQ;
      pc_img += 3;
    end else if (opc == OP_HALT) halt_img = HC_HALT;
    else halt_img = HC_OPCODE;
  endtask

  task automatic predict_word(bit wop, logic [15:0] a, logic [7:0] v, output result_t r);
    r = '0;
    if (!wop) begin
      if (a < MEM_BYTES) mem_img[a] = v;
      else halt_img = HC_BOUNDS;
    end else if (halt_img == HC_RUN) exec_instr(r);
    r.halt_code = halt_img;
    r.pc = pc_img;
    r.flag = flag_img;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet_in || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ehc / epc of -1 mean no typed expectation
  task automatic send(bit wop, logic [15:0] a, logic [7:0] v,
                      int ehc = -1, longint epc = -1);
    result_t r;
    int g;
    predict_word(wop, a, v, r);
    if (ehc >= 0 && r.halt_code != ehc) report_mismatch("typed halt_code", r.halt_code, ehc);
    if (epc >= 0 && r.pc != epc) report_mismatch("typed pc", r.pc, epc);
    expected_q.push_back(r);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    op <= wop;
    address <= a;
    byte_value <= v;
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  task automatic put_instr(logic [7:0] bytes [$], int ehc = -1);
    foreach (bytes[i]) send(0, 16'(pc_img + i), bytes[i]);
    send(1, 16'($urandom), 8'($urandom), ehc);
  endtask

  typedef struct {
    bit     wop;
    int     a;
    int     v;
    int     ehc;
    longint epc;
  } row_t;

  row_t dir_tab [] = '{
    '{1, 0, 0, HC_RUN, 7},                 // zero memory decodes as load r0
    '{0, 4095, -128, -1, -1},
    '{0, 4000, 127, -1, -1},
    '{0, 4001, 8'h80, -1, -1},
    '{0, 7, OP_CMP, -1, -1},
    '{1, 0, 0, HC_RUN, 10},
    '{0, 10, OP_JMP, -1, -1},
    '{0, 15, CC_EQ, -1, -1},
    '{1, 0, 0, HC_RUN, 0},
    '{0, 3, 8'hA0, -1, -1},                // load r1 <- word[4000]
    '{0, 4, 8'h0F, -1, -1},
    '{0, 1, 1, -1, -1},
    '{1, 0, 0, HC_RUN, 7},
    '{0, 7, OP_STORE, -1, -1},             // store r1 -> word[4091], last legal word
    '{0, 8, 1, -1, -1},
    '{0, 10, 8'hFB, -1, -1},
    '{0, 11, 8'h0F, -1, -1},
    '{0, 12, 0, -1, -1},
    '{0, 13, 0, -1, -1},
    '{1, 0, 0, HC_RUN, 14}
  };

  task automatic random_instr();
    logic [7:0] b [$];
    int k, j;
    k = $urandom_range(0, 11);
    if (pc_img > 200 || k == 0) begin
      j = $urandom_range(0, 150);
      b = '{OP_JMP, j[7:0], 0, 0, 0, 8'($urandom_range(0, 5))};
    end else if (k <= 4) begin
      j = $urandom_range(0, REG_COUNT - 1);
      if ($urandom_range(0, 1) && regs_img[j] <= MEM_BYTES - 5)
        b = '{(k <= 2) ? OP_LOAD : OP_STORE, 8'($urandom_range(0, 15)),
              8'($urandom_range(1, 255)), j[7:0], 8'($urandom), 8'($urandom),
              8'($urandom)};
      else begin
        j = $urandom_range(3000, MEM_BYTES - 5);
        b = '{(k <= 2) ? OP_LOAD : OP_STORE, 8'($urandom_range(0, 15)), 0,
              j[7:0], j[15:8], 0, 0};
      end
    end else if (k <= 8) begin
      b = '{8'(OP_ADD + k - 5), 8'($urandom_range(0, 15)),
            (k >= 7) ? 8'($urandom) : 8'($urandom_range(0, 15)),
            8'($urandom_range(0, 15))};
    end else
      b = '{OP_CMP, 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15))};
    put_instr(b);
  endtask

  task automatic final_fault();
    int bad;
    case ($urandom_range(0, 6))
      0: put_instr('{OP_HALT}, HC_HALT);
      1: put_instr('{8'($urandom_range(9, 255))}, HC_OPCODE);
      2: put_instr('{OP_JMP, 0, 0, 0, 0, 8'($urandom_range(6, 255))}, HC_COND);
      3: begin
        bad = $urandom_range(16, 255);
        put_instr('{OP_ADD, bad[7:0], 0, 0}, HC_BOUNDS);
      end
      4: send(0, 16'($urandom_range(MEM_BYTES, 65535)), 8'($urandom), HC_BOUNDS);
      5: begin
        // jump near the top, then a jump there runs past memory
        put_instr('{OP_JMP, 8'hFB, 8'h0F, 0, 0, CC_ALWAYS}, HC_RUN);
        put_instr('{OP_JMP}, HC_BOUNDS);
      end
      default: put_instr('{OP_LOAD, 1, 0, 8'hFC, 8'h0F, 0, 0}, HC_BOUNDS);
    endcase
  endtask

  initial begin
    foreach (mem_img[i]) mem_img[i] = 0;
    foreach (regs_img[i]) regs_img[i] = 0;
    pc_img = 0;
    flag_img = FL_NONE;
    halt_img = HC_RUN;
    repeat (3) @(posedge clk);
    rst <= 0;
    foreach (dir_tab[i])
      send(dir_tab[i].wop, 16'(dir_tab[i].a), 8'(dir_tab[i].v), dir_tab[i].ehc,
           dir_tab[i].epc);
    while (n_items < 500) begin
      if (n_items % 97 < 15) quiet_in = 1;
      else quiet_in = 0;
      if ($urandom_range(0, 9) == 0)
        send(0, 16'($urandom_range(3000, MEM_BYTES - 1)), 8'($urandom));
      else random_instr();
    end
    final_fault();
    // machine is stuck now: steps report state, writes still land
    send(0, 16'hFFFF, 8'($urandom), HC_BOUNDS);
    repeat (12) send(1'($urandom), 16'($urandom), 8'($urandom));
    in_valid <= 0;
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet_in || $urandom_range(0, 9) < 6) begin
      out_stall <= 0;
    end else begin
      out_stall <= 1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report_mismatch("result word with none pending", 0, 0);
      else begin
        got_exp = expected_q.pop_front();
        if (halt_code != got_exp.halt_code)
          report_mismatch("halt_code", halt_code, got_exp.halt_code);
        if (program_counter != got_exp.pc)
          report_mismatch("program_counter", program_counter, got_exp.pc);
        if (compare_flag != got_exp.flag)
          report_mismatch("compare_flag", compare_flag, got_exp.flag);
        if (reg_write_valid != got_exp.rwv)
          report_mismatch("reg_write_valid", reg_write_valid, got_exp.rwv);
        if (reg_number != got_exp.rn) report_mismatch("reg_number", reg_number, got_exp.rn);
        if (reg_value != got_exp.rval) report_mismatch("reg_value", reg_value, got_exp.rval);
        if (mem_write_valid != got_exp.mwv)
          report_mismatch("mem_write_valid", mem_write_valid, got_exp.mwv);
        if (mem_address != got_exp.ma) report_mismatch("mem_address", mem_address, got_exp.ma);
        if (mem_value != got_exp.mval) report_mismatch("mem_value", mem_value, got_exp.mval);
      end
    end
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
